/* hdl/gft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grammar tokenizer package
// Shared constants, token kinds, character codes and small byte classifiers.
// ----------------------------------------------------------------------------
package gft_pkg;

  localparam int unsigned DEF_LINE_BITS   = 16;
  localparam int unsigned DEF_COLUMN_BITS = 12;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;
  localparam int unsigned LEN_BITS        = 12;

  localparam logic [LEN_BITS-1:0] COUNT_MAX = '1;

  // Token kinds.
  localparam logic [3:0] TK_NONTERM = 4'd0;
  localparam logic [3:0] TK_DERIVE  = 4'd1;
  localparam logic [3:0] TK_OR      = 4'd2;
  localparam logic [3:0] TK_AND     = 4'd3;
  localparam logic [3:0] TK_NOT     = 4'd4;
  localparam logic [3:0] TK_SEMI    = 4'd5;
  localparam logic [3:0] TK_STRING  = 4'd6;
  localparam logic [3:0] TK_EPSILON = 4'd7;
  localparam logic [3:0] TK_EOF     = 4'd8;
  localparam logic [3:0] TK_INVALID = 4'd9;

  // Result kinds.
  localparam logic RK_LEXEME = 1'b0;
  localparam logic RK_TOKEN  = 1'b1;

  // Request kinds.
  localparam logic RQ_CHAR = 1'b0;
  localparam logic RQ_EOF  = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_E      = 8'h65;

  localparam logic [LEN_BITS-1:0] KEYWORD_LEN = LEN_BITS'(7);

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } gft_qstat_t;

  function automatic logic is_ident(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || (b == CH_USCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Letters of the word epsilon, by position.
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h65;
      3'd1:    c = 8'h70;
      3'd2:    c = 8'h73;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h6C;
      3'd5:    c = 8'h6F;
      3'd6:    c = 8'h6E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [LEN_BITS-1:0] count_inc(input logic [LEN_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + LEN_BITS'(1);
  endfunction

endpackage

/* hdl/gft_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grammar tokenizer front end
// Accepts one byte or end mark per cycle while the queue is not full, tracks the
// scan state and builds the results of a request (none, one or two) as one queue entry.
// ----------------------------------------------------------------------------
module gft_front import gft_pkg::*; #(
  parameter int unsigned LINE_BITS   = DEF_LINE_BITS,
  parameter int unsigned COLUMN_BITS = DEF_COLUMN_BITS,
  localparam int unsigned RES_W      = 1 + 8 + 4 + LINE_BITS + COLUMN_BITS + LEN_BITS,
  localparam int unsigned ENT_W      = 2 * RES_W + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_eof_i,
  input  logic [7:0]       in_byte_i,
  input  gft_qstat_t       qstat_i,
  output logic             push_o,
  output logic [ENT_W-1:0] entry_o
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_STRING = 3'd2,
    MODE_ESCAPE = 3'd3,
    MODE_DASH   = 3'd4
  } mode_e;

  typedef struct packed {
    logic [LEN_BITS-1:0]    len;
    logic [COLUMN_BITS-1:0] col;
    logic [LINE_BITS-1:0]   line;
    logic [3:0]             tok;
    logic [7:0]             lex;
    logic                   kind;
  } res_t;

  mode_e                  mode_q, mode_d;
  logic [LINE_BITS-1:0]   line_q, line_d, sline_q, sline_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, scol_q, scol_d;
  logic [LEN_BITS-1:0]    count_q, count_d, cnt1, cnt2;
  logic                   kw_q, kw_d;
  logic                   accept;
  logic                   a_v, b_v, idle_go;
  res_t                   res_a, res_b;

  function automatic res_t mk(input logic kind, input logic [7:0] lex,
                              input logic [3:0] tok, input logic [LINE_BITS-1:0] line,
                              input logic [COLUMN_BITS-1:0] col,
                              input logic [LEN_BITS-1:0] len);
    res_t r;
    r.kind = kind;
    r.lex  = lex;
    r.tok  = tok;
    r.line = line;
    r.col  = col;
    r.len  = len;
    return r;
  endfunction

  assign in_ready_o = ~qstat_i.full;
  assign accept     = in_valid_i & in_ready_o;
  assign cnt1       = count_inc(count_q);
  assign cnt2       = count_inc(cnt1);

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    count_d = count_q;
    kw_d    = kw_q;
    a_v     = 1'b0;
    b_v     = 1'b0;
    idle_go = 1'b0;
    res_a   = '0;
    res_b   = '0;

    if (in_eof_i) begin
      // Close whatever is open, then report the end mark at the current position.
      unique case (mode_q)
        MODE_IDENT: begin
          a_v = 1'b1;
          if (kw_q && count_q == KEYWORD_LEN) begin
            res_a = mk(RK_TOKEN, 8'h00, TK_EPSILON, sline_q, scol_q, '0);
          end else begin
            res_a = mk(RK_TOKEN, 8'h00, TK_NONTERM, sline_q, scol_q, count_q);
          end
        end
        MODE_STRING, MODE_ESCAPE: begin
          a_v   = 1'b1;
          res_a = mk(RK_TOKEN, 8'h00, TK_INVALID, sline_q, scol_q, count_q);
        end
        MODE_DASH: begin
          a_v   = 1'b1;
          res_a = mk(RK_TOKEN, CH_DASH, TK_INVALID, sline_q, scol_q, LEN_BITS'(1));
        end
        default: begin
        end
      endcase
      mode_d = MODE_IDLE;
      b_v    = 1'b1;
      res_b  = mk(RK_TOKEN, 8'h00, TK_EOF, line_q, col_q, '0);
    end else begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (is_ident(in_byte_i)) begin
            count_d = cnt1;
            kw_d    = kw_q && (count_q < KEYWORD_LEN) &&
                      (kw_char(count_q[2:0]) == in_byte_i);
            a_v     = 1'b1;
            res_a   = mk(RK_LEXEME, in_byte_i, TK_NONTERM, sline_q, scol_q, cnt1);
          end else begin
            a_v = 1'b1;
            if (kw_q && count_q == KEYWORD_LEN) begin
              res_a = mk(RK_TOKEN, 8'h00, TK_EPSILON, sline_q, scol_q, '0);
            end else begin
              res_a = mk(RK_TOKEN, 8'h00, TK_NONTERM, sline_q, scol_q, count_q);
            end
            mode_d  = MODE_IDLE;
            idle_go = 1'b1;
          end
        end
        MODE_STRING: begin
          if (in_byte_i == CH_QUOTE) begin
            a_v    = 1'b1;
            mode_d = MODE_IDLE;
            if (count_q == '0) begin
              res_a = mk(RK_TOKEN, 8'h00, TK_EPSILON, sline_q, scol_q, '0);
            end else begin
              res_a = mk(RK_TOKEN, 8'h00, TK_STRING, sline_q, scol_q, count_q);
            end
          end else if (in_byte_i == CH_BSLASH) begin
            mode_d = MODE_ESCAPE;
          end else begin
            count_d = cnt1;
            a_v     = 1'b1;
            res_a   = mk(RK_LEXEME, in_byte_i, TK_STRING, sline_q, scol_q, cnt1);
          end
        end
        MODE_ESCAPE: begin
          mode_d  = MODE_STRING;
          count_d = cnt1;
          a_v     = 1'b1;
          if (in_byte_i == CH_QUOTE) begin
            res_a = mk(RK_LEXEME, CH_QUOTE, TK_STRING, sline_q, scol_q, cnt1);
          end else begin
            // Backslash kept; a second one escapes anew, other bytes are plain input.
            res_a = mk(RK_LEXEME, CH_BSLASH, TK_STRING, sline_q, scol_q, cnt1);
            if (in_byte_i == CH_BSLASH) begin
              mode_d = MODE_ESCAPE;
            end else begin
              count_d = cnt2;
              b_v     = 1'b1;
              res_b   = mk(RK_LEXEME, in_byte_i, TK_STRING, sline_q, scol_q, cnt2);
            end
          end
        end
        MODE_DASH: begin
          mode_d = MODE_IDLE;
          a_v    = 1'b1;
          if (in_byte_i == CH_GT) begin
            res_a = mk(RK_TOKEN, 8'h00, TK_DERIVE, sline_q, scol_q, LEN_BITS'(2));
          end else begin
            res_a   = mk(RK_TOKEN, CH_DASH, TK_INVALID, sline_q, scol_q, LEN_BITS'(1));
            idle_go = 1'b1;
          end
        end
        default: begin
          mode_d  = MODE_IDLE;
          idle_go = 1'b1;
        end
      endcase

      // Scan the byte as the first byte of a new token.
      if (idle_go && !is_space(in_byte_i)) begin
        if (is_ident(in_byte_i)) begin
          sline_d = line_q;
          scol_d  = col_q;
          count_d = LEN_BITS'(1);
          kw_d    = (in_byte_i == CH_E);
          mode_d  = MODE_IDENT;
          b_v     = 1'b1;
          res_b   = mk(RK_LEXEME, in_byte_i, TK_NONTERM, line_q, col_q, LEN_BITS'(1));
        end else if (in_byte_i == CH_QUOTE) begin
          sline_d = line_q;
          scol_d  = col_q;
          count_d = '0;
          mode_d  = MODE_STRING;
        end else if (in_byte_i == CH_DASH) begin
          sline_d = line_q;
          scol_d  = col_q;
          count_d = '0;
          mode_d  = MODE_DASH;
        end else begin
          b_v = 1'b1;
          priority if (in_byte_i == CH_BAR) begin
            res_b = mk(RK_TOKEN, 8'h00, TK_OR, line_q, col_q, LEN_BITS'(1));
          end else if (in_byte_i == CH_AMP) begin
            res_b = mk(RK_TOKEN, 8'h00, TK_AND, line_q, col_q, LEN_BITS'(1));
          end else if (in_byte_i == CH_TILDE) begin
            res_b = mk(RK_TOKEN, 8'h00, TK_NOT, line_q, col_q, LEN_BITS'(1));
          end else if (in_byte_i == CH_SEMI) begin
            res_b = mk(RK_TOKEN, 8'h00, TK_SEMI, line_q, col_q, LEN_BITS'(1));
          end else begin
            res_b = mk(RK_TOKEN, in_byte_i, TK_INVALID, line_q, col_q, LEN_BITS'(1));
          end
        end
      end

      // Position of the next byte.
      if (in_byte_i == CH_LF || in_byte_i == CH_CR) begin
        line_d = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
        col_d  = COLUMN_BITS'(1);
      end else if (col_q != '1) begin
        col_d = col_q + COLUMN_BITS'(1);
      end
    end
  end

  assign push_o  = accept & (a_v | b_v);
  assign entry_o = a_v ? {b_v, res_b, res_a} : {1'b0, res_b, res_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= LINE_BITS'(1);
      col_q   <= COLUMN_BITS'(1);
      sline_q <= LINE_BITS'(1);
      scol_q  <= COLUMN_BITS'(1);
      count_q <= '0;
      kw_q    <= 1'b1;
    end else if (accept) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      count_q <= count_d;
      kw_q    <= kw_d;
    end
  end

  a_eof_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_eof_i) |=> (mode_q == MODE_IDLE))
    else $error("scan mode not idle after end mark");

  a_eof_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_eof_i) |-> push_o)
    else $error("end mark produced no results");

endmodule

/* hdl/gft_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grammar tokenizer result queue
// Small first-in first-out buffer of result entries between front and back.
// ----------------------------------------------------------------------------
module gft_queue import gft_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output gft_qstat_t       qstat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign rdata_o       = mem_q[rd_q];
  assign qstat_o.full  = (cnt_q == CNT_FULL);
  assign qstat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && qstat_o.full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && qstat_o.empty))
    else $error("pop from an empty queue");

endmodule

/* hdl/gft_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grammar tokenizer back end
// Holds one queue entry and sends its one or two results out in order.
// ----------------------------------------------------------------------------
module gft_back import gft_pkg::*; #(
  parameter int unsigned RES_W  = 53,
  parameter int unsigned OUT_DW = 56,
  localparam int unsigned ENT_W = 2 * RES_W + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gft_qstat_t        qstat_i,
  input  logic [ENT_W-1:0]  entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_DW-1:0] out_data_o,
  output logic              out_user_o,
  output logic              out_last_o
);

  logic [ENT_W-1:0] entry_q;
  logic             valid_q, phase_q;
  logic [RES_W-1:0] cur;
  logic             beat, last_beat, load;

  assign cur       = phase_q ? entry_q[2*RES_W-1:RES_W] : entry_q[RES_W-1:0];
  assign last_beat = phase_q | ~entry_q[2*RES_W];
  assign beat      = valid_q & out_ready_i;
  assign load      = ~valid_q | (beat & last_beat);
  assign pop_o     = load & ~qstat_i.empty;

  assign out_valid_o = valid_q;
  assign out_data_o  = OUT_DW'(cur[RES_W-1:1]);
  assign out_user_o  = cur[0];
  assign out_last_o  = last_beat;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      entry_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      valid_q <= ~qstat_i.empty;
      phase_q <= 1'b0;
    end else if (beat) begin
      phase_q <= 1'b1;
    end
  end

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !last_beat) |=> (valid_q && phase_q))
    else $error("second result of an entry was lost");

endmodule

/* hdl/grammar_file_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grammar file tokenizer
// Streaming lexer for BNF-style grammar text, one byte or end mark a request.
// ----------------------------------------------------------------------------
// The block takes grammar text as a stream of requests, each either a text
// byte (tuser low, byte in tdata) or an end-of-file mark (tuser high), and
// returns a stream of results. Identifier and string content bytes come out
// as lexeme results while the token is being built, followed by one token
// result with its kind, 1-based start line and column and its length; the
// word epsilon and the empty string give an epsilon token of length 0, and a
// consumer drops the lexeme results that went before it. A request causes
// zero, one or two results, and tlast marks the last result of a request.
// A request is accepted every cycle while the result queue has room, so text
// can stream at one byte per clock. Results leave at one per clock while
// tready is high, so the output port sets the sustained rate, and the queue
// absorbs short bursts of requests that cause two results. When the queue
// and the output register are empty, the first result of a request passes
// through the queue and then the back-end entry register before it is
// offered. End of file closes any open token and gives an eof token at the
// current position; the position is kept, so more text may follow. Line,
// column and length counters saturate at their maximum.
// ----------------------------------------------------------------------------
module grammar_file_tokenizer import gft_pkg::*; #(
  parameter int unsigned LINE_BITS   = DEF_LINE_BITS,
  parameter int unsigned COLUMN_BITS = DEF_COLUMN_BITS,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int unsigned RES_W      = 1 + 8 + 4 + LINE_BITS + COLUMN_BITS + LEN_BITS,
  localparam int unsigned OUT_DW     = ((RES_W - 1 + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // char_byte
  input  logic              s_axis_tuser,  // req_type
  // Result stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // From bit 0 up: lexeme_byte, token_kind, start_line, start_column,
  // lexeme_length, zero fill.
  output logic [OUT_DW-1:0] m_axis_tdata,
  output logic              m_axis_tuser,  // result_kind
  output logic              m_axis_tlast   // last_result
);

  localparam int unsigned ENT_W = 2 * RES_W + 1;

  // Entries carry {second result valid, second result, first result}; each
  // result is packed with result_kind in bit 0 and the tdata fields above it.
  gft_qstat_t       qstat;
  logic             push, pop;
  logic [ENT_W-1:0] wr_entry, rd_entry;

  // Front end: scan state, position tracking and result building.
  gft_front #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_eof_i   (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .qstat_i    (qstat),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  // Queue that lets the scanner run on while results wait on the output.
  gft_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .qstat_o (qstat)
  );

  // Back end: serializes each entry onto the result stream.
  gft_back #(
    .RES_W  (RES_W),
    .OUT_DW (OUT_DW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .entry_i     (rd_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
